// ----- rtl/ifrc_pkg.sv -----
// Shared types, constants and helpers of the image fit rectangle calculator.
package ifrc_pkg;

  localparam int DIM_BITS   = 12;
  localparam int PROD_BITS  = 2 * DIM_BITS;
  localparam int DIVD_BITS  = PROD_BITS + 2;
  localparam int FACTOR_CAP = 2;

  localparam logic [2:0] MODE_FILL      = 3'd0;
  localparam logic [2:0] MODE_HIDDEN    = 3'd1;
  localparam logic [2:0] MODE_MEET      = 3'd2;
  localparam logic [2:0] MODE_MEET_BEST = 3'd3;
  localparam logic [2:0] MODE_SLICE     = 3'd4;

  typedef logic [DIM_BITS-1:0]  dim_t;
  typedef logic [PROD_BITS-1:0] prod_t;

  typedef enum logic [1:0] {
    KIND_FILL,
    KIND_HIDDEN,
    KIND_MEET,
    KIND_SLICE
  } kind_t;

  typedef struct packed {
    dim_t       surface_width;
    dim_t       surface_height;
    dim_t       image_width;
    dim_t       image_height;
    logic [2:0] fit_mode;
  } req_t;

  typedef struct packed {
    dim_t target_width;
    dim_t target_height;
    dim_t source_width;
    dim_t source_height;
    logic size_error;
  } rsp_t;

  typedef struct packed {
    dim_t  sw;
    dim_t  sh;
    dim_t  iw;
    dim_t  ih;
    dim_t  num;
    dim_t  den;
    kind_t kind;
    logic  err;
  } info_t;

  typedef struct packed {
    info_t info;
    dim_t  tw;
    dim_t  th;
  } side_t;

  function automatic dim_t min_dim(dim_t a, dim_t b);
    return (a < b) ? a : b;
  endfunction

endpackage

// ----- rtl/ifrc_ratio.sv -----
// Two-stage front end: cross products, ratio selection, factor cap and error detection.
module ifrc_ratio (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_v,
  input  ifrc_pkg::req_t  in_req,
  output logic            out_v,
  output ifrc_pkg::info_t out_info
);

  logic            a_v_r;
  ifrc_pkg::req_t  a_req_r;
  ifrc_pkg::prod_t pw_r;
  ifrc_pkg::prod_t ph_r;
  logic            b_v_r;
  ifrc_pkg::info_t b_info_r;
  ifrc_pkg::info_t b_info_nxt;
  logic            w_side;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_v;
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_req_r  <= in_req;
      pw_r     <= ifrc_pkg::prod_t'(in_req.surface_width) *
                  ifrc_pkg::prod_t'(in_req.image_height);
      ph_r     <= ifrc_pkg::prod_t'(in_req.surface_height) *
                  ifrc_pkg::prod_t'(in_req.image_width);
      b_info_r <= b_info_nxt;
    end
  end

  always_comb begin
    b_info_nxt    = '0;
    b_info_nxt.sw = a_req_r.surface_width;
    b_info_nxt.sh = a_req_r.surface_height;
    b_info_nxt.iw = a_req_r.image_width;
    b_info_nxt.ih = a_req_r.image_height;
    priority if (a_req_r.fit_mode == ifrc_pkg::MODE_FILL) begin
      b_info_nxt.kind = ifrc_pkg::KIND_FILL;
    end else if (a_req_r.fit_mode == ifrc_pkg::MODE_MEET ||
                 a_req_r.fit_mode == ifrc_pkg::MODE_MEET_BEST) begin
      b_info_nxt.kind = ifrc_pkg::KIND_MEET;
    end else if (a_req_r.fit_mode == ifrc_pkg::MODE_SLICE) begin
      b_info_nxt.kind = ifrc_pkg::KIND_SLICE;
    end else begin
      b_info_nxt.kind = ifrc_pkg::KIND_HIDDEN;
    end
    w_side = (b_info_nxt.kind == ifrc_pkg::KIND_SLICE) ? (pw_r >= ph_r) : (pw_r <= ph_r);
    b_info_nxt.num = w_side ? a_req_r.surface_width : a_req_r.surface_height;
    b_info_nxt.den = w_side ? a_req_r.image_width : a_req_r.image_height;
    if (a_req_r.fit_mode == ifrc_pkg::MODE_MEET_BEST &&
        (ifrc_pkg::DIM_BITS + 2)'(b_info_nxt.num) >
        (ifrc_pkg::DIM_BITS + 2)'(b_info_nxt.den) *
        (ifrc_pkg::DIM_BITS + 2)'(ifrc_pkg::FACTOR_CAP)) begin
      b_info_nxt.num = ifrc_pkg::dim_t'(ifrc_pkg::FACTOR_CAP);
      b_info_nxt.den = ifrc_pkg::dim_t'(1);
    end
    b_info_nxt.err = (b_info_nxt.kind == ifrc_pkg::KIND_MEET ||
                      b_info_nxt.kind == ifrc_pkg::KIND_SLICE) &&
                     (a_req_r.image_width == '0 || a_req_r.image_height == '0 ||
                      (b_info_nxt.kind == ifrc_pkg::KIND_SLICE && b_info_nxt.num == '0));
  end

  assign out_v    = b_v_r;
  assign out_info = b_info_r;

endmodule

// ----- rtl/ifrc_div.sv -----
// Two-lane pipelined rounding divider with a shared divisor, one quotient bit per stage.
module ifrc_div (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_v,
  input  ifrc_pkg::prod_t in_a0,
  input  ifrc_pkg::prod_t in_a1,
  input  ifrc_pkg::dim_t  in_b,
  input  ifrc_pkg::side_t in_side,
  output logic            out_v,
  output ifrc_pkg::dim_t  out_q0,
  output ifrc_pkg::dim_t  out_q1,
  output ifrc_pkg::side_t out_side
);

  localparam int D  = ifrc_pkg::DIM_BITS;
  localparam int AW = ifrc_pkg::DIVD_BITS;

  logic [D:0]      v_r;
  ifrc_pkg::side_t side_r [D+1];
  logic [D:0]      b_r    [D];
  logic            zero_r [D+1];
  logic            ovf0_r [D+1];
  logic            ovf1_r [D+1];
  ifrc_pkg::dim_t  q0_r   [D+1];
  ifrc_pkg::dim_t  q1_r   [D+1];
  logic [AW-1:0]   r0_r   [D];
  logic [AW-1:0]   r1_r   [D];
  logic [AW-1:0]   a0_nxt;
  logic [AW-1:0]   a1_nxt;
  logic [AW-1:0]   lim_nxt;

  assign a0_nxt  = (AW'(in_a0) << 1) + AW'(in_b);
  assign a1_nxt  = (AW'(in_a1) << 1) + AW'(in_b);
  assign lim_nxt = AW'({in_b, 1'b0}) << D;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[D-1:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= in_side;
      b_r[0]    <= {in_b, 1'b0};
      zero_r[0] <= (in_b == '0);
      ovf0_r[0] <= (a0_nxt >= lim_nxt);
      ovf1_r[0] <= (a1_nxt >= lim_nxt);
      q0_r[0]   <= '0;
      q1_r[0]   <= '0;
      r0_r[0]   <= a0_nxt;
      r1_r[0]   <= a1_nxt;
    end
  end

  for (genvar k = 1; k <= D; k++) begin : g_stage
    localparam int BIT = D - k;
    logic [AW-1:0] sub_b;
    logic          ge0;
    logic          ge1;

    assign sub_b = AW'(b_r[k-1]) << BIT;
    assign ge0   = (r0_r[k-1] >= sub_b);
    assign ge1   = (r1_r[k-1] >= sub_b);

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k]     <= side_r[k-1];
        zero_r[k]     <= zero_r[k-1];
        ovf0_r[k]     <= ovf0_r[k-1];
        ovf1_r[k]     <= ovf1_r[k-1];
        q0_r[k]       <= q0_r[k-1] | (ifrc_pkg::dim_t'(ge0) << BIT);
        q1_r[k]       <= q1_r[k-1] | (ifrc_pkg::dim_t'(ge1) << BIT);
      end
    end

    if (k < D) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          b_r[k]  <= b_r[k-1];
          r0_r[k] <= ge0 ? (r0_r[k-1] - sub_b) : r0_r[k-1];
          r1_r[k] <= ge1 ? (r1_r[k-1] - sub_b) : r1_r[k-1];
        end
      end
    end
  end

  assign out_v    = v_r[D];
  assign out_side = side_r[D];
  assign out_q0   = zero_r[D] ? '0 : (ovf0_r[D] ? '1 : q0_r[D]);
  assign out_q1   = zero_r[D] ? '0 : (ovf1_r[D] ? '1 : q1_r[D]);

endmodule

// ----- rtl/image_fit_rect_calculator.sv -----
// Top level of the image fit rectangle calculator.
// Throughput: one request per cycle while in_stall is low; each of the two dividers retires
// one quotient bit per stage for both sides at once, so a new request enters every cycle
// in which in_stall is low.
// A skid register behind the output register absorbs one result while out_stall is high.
// Reset (rst_n low, synchronous) clears all valid bits; payload registers are not reset.
module image_fit_rect_calculator (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  ifrc_pkg::req_t in_req,
  output logic           out_valid,
  input  logic           out_stall,
  output ifrc_pkg::rsp_t out_rsp
);

  logic            en;
  logic            info_v;
  ifrc_pkg::info_t info;
  logic            c_v_r;
  ifrc_pkg::info_t c_info_r;
  ifrc_pkg::prod_t c_a0_r;
  ifrc_pkg::prod_t c_a1_r;
  ifrc_pkg::side_t c_side;
  logic            d1_v;
  ifrc_pkg::dim_t  d1_q0;
  ifrc_pkg::dim_t  d1_q1;
  ifrc_pkg::side_t d1_side;
  logic            d_v_r;
  ifrc_pkg::side_t d_side_r;
  ifrc_pkg::side_t d_side_nxt;
  logic            e_v_r;
  ifrc_pkg::side_t e_side_r;
  ifrc_pkg::prod_t e_a0_r;
  ifrc_pkg::prod_t e_a1_r;
  logic            d2_v;
  ifrc_pkg::dim_t  d2_q0;
  ifrc_pkg::dim_t  d2_q1;
  ifrc_pkg::side_t d2_side;
  ifrc_pkg::rsp_t  fin_rsp;
  logic            out_valid_r;
  ifrc_pkg::rsp_t  out_rsp_r;
  logic            skid_v_r;
  ifrc_pkg::rsp_t  skid_r;

  assign en       = !skid_v_r;
  assign in_stall = skid_v_r;

  ifrc_ratio u_ratio (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (in_valid),
    .in_req   (in_req),
    .out_v    (info_v),
    .out_info (info)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
      e_v_r <= 1'b0;
    end else if (en) begin
      c_v_r <= info_v;
      d_v_r <= d1_v;
      e_v_r <= d_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_info_r <= info;
      c_a0_r   <= ifrc_pkg::prod_t'(info.iw) * ifrc_pkg::prod_t'(info.num);
      c_a1_r   <= ifrc_pkg::prod_t'(info.ih) * ifrc_pkg::prod_t'(info.num);
      d_side_r <= d_side_nxt;
      e_side_r <= d_side_r;
      e_a0_r   <= ifrc_pkg::prod_t'(d_side_r.tw) * ifrc_pkg::prod_t'(d_side_r.info.den);
      e_a1_r   <= ifrc_pkg::prod_t'(d_side_r.th) * ifrc_pkg::prod_t'(d_side_r.info.den);
    end
  end

  always_comb begin
    c_side      = '0;
    c_side.info = c_info_r;
  end

  ifrc_div u_div_target (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (c_v_r),
    .in_a0    (c_a0_r),
    .in_a1    (c_a1_r),
    .in_b     (c_info_r.den),
    .in_side  (c_side),
    .out_v    (d1_v),
    .out_q0   (d1_q0),
    .out_q1   (d1_q1),
    .out_side (d1_side)
  );

  always_comb begin
    d_side_nxt = d1_side;
    if (d1_side.info.kind == ifrc_pkg::KIND_SLICE) begin
      d_side_nxt.tw = ifrc_pkg::min_dim(d1_q0, d1_side.info.sw);
      d_side_nxt.th = ifrc_pkg::min_dim(d1_q1, d1_side.info.sh);
    end else begin
      d_side_nxt.tw = d1_q0;
      d_side_nxt.th = d1_q1;
    end
  end

  ifrc_div u_div_source (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (e_v_r),
    .in_a0    (e_a0_r),
    .in_a1    (e_a1_r),
    .in_b     (e_side_r.info.num),
    .in_side  (e_side_r),
    .out_v    (d2_v),
    .out_q0   (d2_q0),
    .out_q1   (d2_q1),
    .out_side (d2_side)
  );

  always_comb begin
    fin_rsp = '0;
    unique case (d2_side.info.kind)
      ifrc_pkg::KIND_FILL: begin
        fin_rsp.target_width  = d2_side.info.sw;
        fin_rsp.target_height = d2_side.info.sh;
        fin_rsp.source_width  = d2_side.info.iw;
        fin_rsp.source_height = d2_side.info.ih;
      end
      ifrc_pkg::KIND_HIDDEN: begin
        fin_rsp.target_width  = ifrc_pkg::min_dim(d2_side.info.sw, d2_side.info.iw);
        fin_rsp.target_height = ifrc_pkg::min_dim(d2_side.info.sh, d2_side.info.ih);
        fin_rsp.source_width  = fin_rsp.target_width;
        fin_rsp.source_height = fin_rsp.target_height;
      end
      ifrc_pkg::KIND_MEET: begin
        fin_rsp.target_width  = d2_side.tw;
        fin_rsp.target_height = d2_side.th;
        fin_rsp.source_width  = d2_side.info.iw;
        fin_rsp.source_height = d2_side.info.ih;
      end
      ifrc_pkg::KIND_SLICE: begin
        fin_rsp.target_width  = d2_side.tw;
        fin_rsp.target_height = d2_side.th;
        fin_rsp.source_width  = d2_q0;
        fin_rsp.source_height = d2_q1;
      end
      default: begin
        fin_rsp = '0;
      end
    endcase
    if (d2_side.info.err) begin
      fin_rsp            = '0;
      fin_rsp.size_error = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r <= skid_v_r || d2_v;
      skid_v_r    <= 1'b0;
    end else if (d2_v && en) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      out_rsp_r <= skid_v_r ? skid_r : fin_rsp;
    end else if (en) begin
      skid_r <= fin_rsp;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule
